[design/ffba_pkg.sv]
package ffba_pkg;

    // Default pool geometry
    localparam int BLOCK_COUNT_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 64;

    // Fixed field widths
    localparam int SIZE_W = 16;
    localparam int OFFS_W = 12;
    localparam int CNT_W  = 7;

    // Request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size_bytes;
        logic [OFFS_W-1:0] free_offset;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [OFFS_W-1:0] block_offset;
        logic [CNT_W-1:0]  free_blocks;
        logic [CNT_W-1:0]  used_blocks;
    } rsp_t;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic cand_set;    // current cell joins the candidate run
        logic cand_first;  // current cell opens the candidate run
        logic cand_clr;    // drop the candidate run
        logic commit;      // mark the candidate run used
        logic release_cur; // release the current cell
        logic kill;        // remove the scan token
    } ctrl_t;

endpackage

[design/ffba_cell.sv]
module ffba_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           token_in,
    input  ffba_pkg::ctrl_t ctrl,
    output logic           token_out,
    output logic           used,
    output logic           first
);

    logic token_reg, used_reg, first_reg, cand_reg, candf_reg;
    logic token_next, used_next, first_next, cand_next, candf_next;
    logic hit, hit_first;

    assign hit       = token_reg & ctrl.cand_set;
    assign hit_first = hit & ctrl.cand_first;

    // Update token, candidate marks and block state
    always_comb begin
        token_next = ctrl.kill ? 1'b0 : token_in;
        used_next  = used_reg;
        first_next = first_reg;
        cand_next  = cand_reg | hit;
        candf_next = candf_reg | hit_first;
        if (ctrl.commit && (cand_reg || hit)) begin
            used_next  = 1'b1;
            first_next = candf_reg | hit_first;
        end
        if (ctrl.release_cur && token_reg) begin
            used_next  = 1'b0;
            first_next = 1'b0;
        end
        if (ctrl.cand_clr) begin
            cand_next  = 1'b0;
            candf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= 1'b0;
            used_reg  <= 1'b0;
            first_reg <= 1'b0;
            cand_reg  <= 1'b0;
            candf_reg <= 1'b0;
        end else begin
            token_reg <= token_next;
            used_reg  <= used_next;
            first_reg <= first_next;
            cand_reg  <= cand_next;
            candf_reg <= candf_next;
        end
    end

    assign token_out = token_reg;
    assign used      = token_reg & used_reg;
    assign first     = token_reg & first_reg;

endmodule

[design/first_fit_block_allocator_unit.sv]
// First-fit block pool allocator. Each request (allocate a byte size, or free a
// byte offset) gives exactly one result with the free and used block counts
// after it. The pool is a row of BLOCK_COUNT cells, one per block; a scan token
// walks the row one cell per clock and stops early on a successful allocation
// or when a freed run ends; a zero-size allocation skips the scan. One request
// is in work at a time; the next may be taken while the previous result waits.
module first_fit_block_allocator_unit #(
    parameter int BLOCK_COUNT = ffba_pkg::BLOCK_COUNT_DEF,
    parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ffba_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ffba_pkg::rsp_t m_data
);

    localparam int CW    = $clog2(BLOCK_COUNT + 1);
    localparam int POS_W = $clog2(BLOCK_COUNT * BLOCK_BYTES) + 1;
    localparam int FB_W  = $clog2(65536 + BLOCK_BYTES) + 1;
    localparam int EXT_W = POS_W + ffba_pkg::OFFS_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

    state_t                      state_reg, state_next;
    logic                        op_reg, op_next;
    logic [ffba_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [ffba_pkg::OFFS_W-1:0] offs_reg, offs_next;
    logic [POS_W-1:0]            pos_reg, pos_next, start_reg, start_next;
    logic [CW-1:0]               found_reg, found_next, len_reg, len_next;
    logic [FB_W-1:0]             fbytes_reg, fbytes_next, fb_sum;
    logic                        clr_reg, clr_next;
    logic                        rok_reg, rok_next;
    logic [ffba_pkg::OFFS_W-1:0] roff_reg, roff_next;
    logic [CW-1:0]               fcnt_reg, fcnt_next, ucnt_reg, ucnt_next;
    ffba_pkg::rsp_t              out_reg, out_next;
    logic                        mv_reg, mv_next;

    ffba_pkg::ctrl_t             ctrl;
    logic [BLOCK_COUNT:0]        tok;
    logic [BLOCK_COUNT-1:0]      used_v, first_v;
    logic                        cur_used, cur_first, last, accept, zero_alloc, hit;
    logic [EXT_W-1:0]            start_ext;

    // Row of cells, token handed to the right each cycle
    genvar g;
    generate
        for (g = 0; g < BLOCK_COUNT; g++) begin : g_cell
            ffba_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .token_in (tok[g]),
                .ctrl     (ctrl),
                .token_out(tok[g+1]),
                .used     (used_v[g]),
                .first    (first_v[g])
            );
        end
    endgenerate

    assign cur_used   = |used_v;
    assign cur_first  = |first_v;
    assign last       = tok[BLOCK_COUNT];
    assign accept     = s_valid && s_ready;
    assign zero_alloc = (s_data.op == ffba_pkg::OP_ALLOC) && (s_data.size_bytes == '0);
    assign tok[0]     = accept && !zero_alloc;
    assign fb_sum     = fbytes_reg + FB_W'(BLOCK_BYTES);
    assign hit        = EXT_W'(pos_reg) == EXT_W'(offs_reg);
    assign start_ext  = EXT_W'(start_reg);

    // Sequencer
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        size_next   = size_reg;
        offs_next   = offs_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        found_next  = found_reg;
        len_next    = len_reg;
        fbytes_next = fbytes_reg;
        clr_next    = clr_reg;
        rok_next    = rok_reg;
        roff_next   = roff_reg;
        fcnt_next   = fcnt_reg;
        ucnt_next   = ucnt_reg;
        out_next    = out_reg;
        mv_next     = mv_reg && !m_ready;
        ctrl        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next     = s_data.op;
                    size_next   = s_data.size_bytes;
                    offs_next   = s_data.free_offset;
                    pos_next    = '0;
                    found_next  = '0;
                    len_next    = '0;
                    fbytes_next = '0;
                    clr_next    = 1'b0;
                    rok_next    = 1'b0;
                    roff_next   = '0;
                    state_next  = zero_alloc ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                pos_next = pos_reg + POS_W'(BLOCK_BYTES);
                if (op_reg == ffba_pkg::OP_ALLOC) begin
                    if (!cur_used) begin
                        ctrl.cand_set   = 1'b1;
                        ctrl.cand_first = (found_reg == '0);
                        if (found_reg == '0) begin
                            start_next = pos_reg;
                        end
                        found_next  = found_reg + CW'(1);
                        fbytes_next = fb_sum;
                        if (fb_sum >= FB_W'(size_reg)) begin
                            ctrl.commit   = 1'b1;
                            ctrl.cand_clr = 1'b1;
                            ctrl.kill     = 1'b1;
                            fcnt_next     = fcnt_reg - found_next;
                            ucnt_next     = ucnt_reg + found_next;
                            rok_next      = 1'b1;
                            roff_next     = ffba_pkg::OFFS_W'((found_reg == '0) ?
                                            EXT_W'(pos_reg) : start_ext);
                            state_next    = ST_FIN;
                        end else if (last) begin
                            ctrl.cand_clr = 1'b1;
                            ctrl.kill     = 1'b1;
                            state_next    = ST_FIN;
                        end
                    end else begin
                        ctrl.cand_clr = 1'b1;
                        found_next    = '0;
                        fbytes_next   = '0;
                        if (last) begin
                            ctrl.kill  = 1'b1;
                            state_next = ST_FIN;
                        end
                    end
                end else begin
                    // Free: find the run head, then release until the run ends
                    if (!clr_reg) begin
                        if (hit && cur_first) begin
                            ctrl.release_cur = 1'b1;
                            clr_next         = 1'b1;
                            len_next         = CW'(1);
                            if (last) begin
                                ctrl.kill  = 1'b1;
                                fcnt_next  = fcnt_reg + CW'(1);
                                ucnt_next  = ucnt_reg - CW'(1);
                                rok_next   = 1'b1;
                                state_next = ST_FIN;
                            end
                        end else if (last) begin
                            ctrl.kill  = 1'b1;
                            state_next = ST_FIN;
                        end
                    end else if (cur_used && !cur_first) begin
                        ctrl.release_cur = 1'b1;
                        len_next         = len_reg + CW'(1);
                        if (last) begin
                            ctrl.kill  = 1'b1;
                            fcnt_next  = fcnt_reg + len_next;
                            ucnt_next  = ucnt_reg - len_next;
                            rok_next   = 1'b1;
                            state_next = ST_FIN;
                        end
                    end else begin
                        ctrl.kill  = 1'b1;
                        fcnt_next  = fcnt_reg + len_reg;
                        ucnt_next  = ucnt_reg - len_reg;
                        rok_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!mv_reg || m_ready) begin
                    out_next.ok           = rok_reg;
                    out_next.block_offset = roff_reg;
                    out_next.free_blocks  = ffba_pkg::CNT_W'(fcnt_reg);
                    out_next.used_blocks  = ffba_pkg::CNT_W'(ucnt_reg);
                    mv_next               = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            fcnt_reg  <= CW'(BLOCK_COUNT);
            ucnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            fcnt_reg  <= fcnt_next;
            ucnt_reg  <= ucnt_next;
        end
        op_reg     <= op_next;
        size_reg   <= size_next;
        offs_reg   <= offs_next;
        pos_reg    <= pos_next;
        start_reg  <= start_next;
        found_reg  <= found_next;
        len_reg    <= len_next;
        fbytes_reg <= fbytes_next;
        clr_reg    <= clr_next;
        rok_reg    <= rok_next;
        roff_reg   <= roff_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok[BLOCK_COUNT:1]))
        else $error("more than one scan token in the row");
    a_idle_no_token: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (tok[BLOCK_COUNT:1] == '0))
        else $error("scan token left in the row while idle");
    a_counts_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (fcnt_reg + ucnt_reg) == CW'(BLOCK_COUNT))
        else $error("free and used counts disagree with the pool size");
`endif

endmodule

[test/first_fit_block_allocator_unit_chk.sv]
`timescale 1ns / 100ps

module first_fit_block_allocator_unit_chk #(
    parameter int BLOCK_COUNT = ffba_pkg::BLOCK_COUNT_DEF,
    parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  ffba_pkg::req_t s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  ffba_pkg::rsp_t m_data,
    output int             fail_count,
    output int             pending
);

    // Pool shadow
    bit             pool_used  [BLOCK_COUNT];
    bit             pool_first [BLOCK_COUNT];
    int unsigned    pool_len   [BLOCK_COUNT];
    int unsigned    n_free;
    int unsigned    n_used;
    ffba_pkg::rsp_t rsp_queue[$];

    function automatic ffba_pkg::rsp_t pack_rsp(bit ok, int unsigned offs);
        ffba_pkg::rsp_t r;
        r.ok           = ok;
        r.block_offset = offs[ffba_pkg::OFFS_W-1:0];
        r.free_blocks  = n_free[ffba_pkg::CNT_W-1:0];
        r.used_blocks  = n_used[ffba_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic ffba_pkg::rsp_t allocate_run(int unsigned size);
        int unsigned need;
        int unsigned found;
        int unsigned start;
        need  = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
        found = 0;
        start = 0;
        if (size == 0 || need > n_free)
            return pack_rsp(1'b0, 0);
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            if (!pool_used[i]) begin
                if (found == 0)
                    start = i;
                found++;
                if (found >= need)
                    break;
            end else begin
                found = 0;
            end
        end
        if (found < need)
            return pack_rsp(1'b0, 0);
        for (int i = 0; i < need; i++) begin
            pool_used[start+i]  = 1'b1;
            pool_first[start+i] = 1'b0;
            pool_len[start+i]   = 0;
        end
        pool_first[start] = 1'b1;
        pool_len[start]   = need;
        n_used += need;
        n_free -= need;
        return pack_rsp(1'b1, start * BLOCK_BYTES);
    endfunction

    function automatic ffba_pkg::rsp_t release_run(int unsigned offs);
        int unsigned idx;
        int unsigned len;
        if (offs % BLOCK_BYTES != 0)
            return pack_rsp(1'b0, 0);
        idx = offs / BLOCK_BYTES;
        if (idx >= BLOCK_COUNT || !pool_first[idx])
            return pack_rsp(1'b0, 0);
        len = pool_len[idx];
        if (len > BLOCK_COUNT - idx)
            len = BLOCK_COUNT - idx;
        for (int i = 0; i < len; i++) begin
            pool_used[idx+i]  = 1'b0;
            pool_first[idx+i] = 1'b0;
            pool_len[idx+i]   = 0;
        end
        n_used = (len > n_used) ? 0 : n_used - len;
        n_free += len;
        if (n_free > BLOCK_COUNT)
            n_free = BLOCK_COUNT;
        return pack_rsp(1'b1, 0);
    endfunction

    assign pending = rsp_queue.size();

    // Predict on each input transfer, compare on each result transfer
    always @(posedge aclk) begin
        ffba_pkg::rsp_t exp_rsp;
        if (!aresetn) begin
            for (int i = 0; i < BLOCK_COUNT; i++) begin
                pool_used[i]  = 1'b0;
                pool_first[i] = 1'b0;
                pool_len[i]   = 0;
            end
            n_free = BLOCK_COUNT;
            n_used = 0;
            rsp_queue.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.op == ffba_pkg::OP_ALLOC)
                    rsp_queue.push_back(allocate_run(s_data.size_bytes));
                else
                    rsp_queue.push_back(release_run(s_data.free_offset));
            end
            if (m_valid && m_ready) begin
                if (rsp_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", m_data);
                end else begin
                    exp_rsp = rsp_queue.pop_front();
                    if (m_data !== exp_rsp) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p, got %p", exp_rsp, m_data);
                    end
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

[test/first_fit_block_allocator_unit_tb.sv]
`timescale 1ns / 100ps

module first_fit_block_allocator_unit_tb;

    localparam int RAND_ITEMS  = 800;
    localparam int CYCLE_LIMIT = 400000;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    ffba_pkg::req_t s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    ffba_pkg::rsp_t m_data;
    int             fail_count;
    int             pending;
    int             cycle_count = 0;
    bit             rx_hold = 1'b0;
    logic [ffba_pkg::OFFS_W-1:0] live_offsets[$];

    first_fit_block_allocator_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    first_fit_block_allocator_unit_chk u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one request and hold it until the transfer, after a random gap
    task automatic send_req(logic op, logic [ffba_pkg::SIZE_W-1:0] size,
                            logic [ffba_pkg::OFFS_W-1:0] offs);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
        repeat (gap) @(posedge aclk);
        s_valid            <= 1'b1;
        s_data.op          <= op;
        s_data.size_bytes  <= size;
        s_data.free_offset <= offs;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
    endtask

    task automatic send_alloc(logic [ffba_pkg::SIZE_W-1:0] size);
        send_req(ffba_pkg::OP_ALLOC, size, ffba_pkg::OFFS_W'($urandom()));
    endtask

    task automatic send_free(logic [ffba_pkg::OFFS_W-1:0] offs);
        send_req(ffba_pkg::OP_FREE, ffba_pkg::SIZE_W'($urandom()), offs);
    endtask

    // Receiver: random wait per result, plus one long hold-off on request
    initial begin
        int gap;
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        int sel;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes and each failure path
        send_alloc(16'd0);
        send_alloc(16'hFFFF);
        send_alloc(16'd4097);
        send_alloc(16'd1);
        send_alloc(16'd64);
        send_alloc(16'd65);
        send_free(12'd0);
        send_free(12'd0);
        send_free(12'd65);
        send_free(12'hFFF);
        send_free(12'd128);
        send_alloc(16'd64);
        send_alloc(16'd4096);
        send_free(12'd64);
        send_free(12'd192);
        send_alloc(16'd3968);
        send_alloc(16'd128);
        send_free(12'd0);
        send_alloc(16'd128);
        send_free(12'd0);
        send_free(12'd128);
        send_alloc(16'd4096);
        send_free(12'd0);

        // Pause until every result has come back
        @(posedge aclk);
        wait (pending == 0);

        // Random: mostly allocs of small runs and frees of queued block-aligned offsets
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2)
                rx_hold = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_alloc(ffba_pkg::SIZE_W'($urandom_range(0, 3) == 0 ?
                                             $urandom_range(0, 4096) :
                                             $urandom_range(1, 640)));
            else if (sel < 50)
                send_alloc(ffba_pkg::SIZE_W'($urandom()));
            else if (sel < 88 && live_offsets.size() > 0) begin
                sel = $urandom_range(0, live_offsets.size() - 1);
                send_free(live_offsets[sel]);
                live_offsets.delete(sel);
            end else if (sel < 94)
                send_free(ffba_pkg::OFFS_W'($urandom_range(0, 63) * 64));
            else
                send_free(ffba_pkg::OFFS_W'($urandom()));
            // After each allocation, queue a random block-aligned offset for later frees
            if (s_data.op == ffba_pkg::OP_ALLOC && live_offsets.size() < 64)
                live_offsets.push_back(ffba_pkg::OFFS_W'($urandom_range(0, 63) * 64));
        end

        @(posedge aclk);
        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
design/ffba_pkg.sv
design/ffba_cell.sv
design/first_fit_block_allocator_unit.sv
test/first_fit_block_allocator_unit_chk.sv
test/first_fit_block_allocator_unit_tb.sv
